@@ rtl/wers_pkg.sv @@
package wers_pkg;

    localparam int unsigned DEF_NUM_TYPES  = 5;
    localparam int unsigned DEF_WINDOW_LEN = 60;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned RESP_W = 32;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned RATE_W = 22;
    localparam int unsigned TOT_W  = 32;
    localparam int unsigned RSUM_W = 48;
    localparam int unsigned SLOT_W = 4;

    localparam int unsigned MAX_TYPE_SLOTS = 16;
    localparam int unsigned RATE_FIELDS    = 5;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    localparam logic REG_SKIP_START = 1'b0;
    localparam logic REG_RATE_EN    = 1'b1;

    localparam logic [CHAR_W-1:0] MARK_START    = 8'h53;
    localparam logic [CHAR_W-1:0] MARK_ROLLBACK = 8'h52;
    localparam logic [CHAR_W-1:0] MARK_ERROR    = 8'h45;
    localparam logic [CHAR_W-1:0] CODE_NONE     = 8'h00;

    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [RATE_W-1:0] RATE_MAX = '1;
    localparam logic [TOT_W-1:0]  TOT_MAX  = '1;
    localparam logic [RSUM_W-1:0] RSUM_MAX = '1;

    // type bytes d n o p s, unused slots never match
    localparam logic [MAX_TYPE_SLOTS-1:0][CHAR_W-1:0] TYPE_CODE = {
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h73, 8'h70, 8'h6f, 8'h6e, 8'h64
    };

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] idx;
    } t_type_hit;

    typedef struct packed {
        logic              fire;
        logic [TIME_W-1:0] now;
    } t_smp_req;

    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] closed_time;
    } t_rate_hdr;

    function automatic t_type_hit find_type(input logic [CHAR_W-1:0] code,
                                            input int unsigned num);
        t_type_hit res;
        res = '0;
        for (int i = MAX_TYPE_SLOTS - 1; i >= 0; i--) begin
            if (i < num && code != CODE_NONE && code == TYPE_CODE[i]) begin
                res.hit = 1'b1;
                res.idx = SLOT_W'(i);
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/wers_window.sv @@
module wers_window #(
    parameter int unsigned NUM_TYPES  = wers_pkg::DEF_NUM_TYPES,
    parameter int unsigned WINDOW_LEN = wers_pkg::DEF_WINDOW_LEN,
    parameter int unsigned TY_W       = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  wers_pkg::t_smp_req                           i_req,
    input  logic [TY_W-1:0]                              i_ty,
    output wers_pkg::t_rate_hdr                          o_hdr,
    output logic [NUM_TYPES-1:0][wers_pkg::RATE_W-1:0]   o_rate_sum
);

    localparam int unsigned CNT_W = wers_pkg::CNT_W;
    localparam int unsigned IDX_W = $clog2(WINDOW_LEN);
    localparam int unsigned SUM_W = CNT_W + IDX_W;
    localparam int unsigned ROW_W = NUM_TYPES * CNT_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_LEN - 1);

    // closed buckets, one row per second slot, all types side by side
    logic [ROW_W-1:0] mem [WINDOW_LEN];
    logic [ROW_W-1:0] r_mem_q;

    logic [WINDOW_LEN-1:0]              r_row_vld;
    logic                               r_rd_hit;
    logic [IDX_W-1:0]                   r_idx;
    logic [wers_pkg::TIME_W-1:0]        r_prev_time;
    logic                               r_time_seen;
    logic [NUM_TYPES-1:0][CNT_W-1:0]    r_cur;
    logic [NUM_TYPES-1:0][SUM_W-1:0]    r_sum;

    logic [NUM_TYPES-1:0][CNT_W-1:0]    cur_inc;
    logic [NUM_TYPES-1:0][SUM_W-1:0]    sum_next;
    logic [ROW_W-1:0]                   exp_row;
    logic [ROW_W-1:0]                   wr_row;
    logic                               adv;
    logic [IDX_W-1:0]                   idx_inc;
    logic [IDX_W-1:0]                   n_idx;
    logic [IDX_W-1:0]                   rd_addr;

    // old row of the current slot, it expires when the slot closes
    assign exp_row = r_rd_hit ? r_mem_q : '0;

    assign adv     = i_req.fire && r_time_seen && (r_prev_time != i_req.now);
    assign idx_inc = (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
    assign n_idx   = adv ? idx_inc : r_idx;
    assign rd_addr = n_idx;

    always_comb begin
        for (int t = 0; t < NUM_TYPES; t++) begin
            cur_inc[t] = r_cur[t];
            if (i_req.fire && i_ty == TY_W'(t) && r_cur[t] != wers_pkg::CNT_MAX) begin
                cur_inc[t] = r_cur[t] + 1'b1;
            end
            wr_row[t*CNT_W +: CNT_W] = cur_inc[t];
            sum_next[t] = SUM_W'({1'b0, r_sum[t]} + (SUM_W + 1)'(cur_inc[t])
                                 - (SUM_W + 1)'(exp_row[t*CNT_W +: CNT_W]));
            o_rate_sum[t] = ((SUM_W + 1)'(sum_next[t]) > (SUM_W + 1)'(wers_pkg::RATE_MAX))
                          ? wers_pkg::RATE_MAX : wers_pkg::RATE_W'(sum_next[t]);
        end
    end

    assign o_hdr.valid       = adv;
    assign o_hdr.closed_time = r_prev_time;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            mem[r_idx] <= wr_row;
        end
        r_mem_q <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld   <= '0;
            r_rd_hit    <= 1'b0;
            r_idx       <= '0;
            r_prev_time <= '0;
            r_time_seen <= 1'b0;
            r_cur       <= '0;
            r_sum       <= '0;
        end else begin
            r_rd_hit <= r_row_vld[rd_addr];
            if (i_req.fire) begin
                r_time_seen <= 1'b1;
                r_prev_time <= i_req.now;
                r_cur       <= adv ? '0 : cur_inc;
            end
            if (adv) begin
                r_sum            <= sum_next;
                r_idx            <= idx_inc;
                r_row_vld[r_idx] <= 1'b1;
            end
        end
    end

endmodule

@@ rtl/windowed_event_rate_stats.sv @@
// channel   direction  handshake                   payload
// input     in         i_in_valid / o_in_ready     i_record_time i_type_char i_status_char
//                                                  i_response_us
// result    out        o_out_valid / i_out_ready   o_rate_* o_counted o_type_* o_error_total
// config    in         psel penable pwrite pready  paddr pwdata prdata
//
// one record per cycle sustained while i_out_ready is high; a record is registered on
// acceptance and its result moves into the result register once that one is empty or taken
// synchronous reset clears all totals, the current bucket and the ring's per-slot
// valid bits, so records are taken right after reset
// the input register can still take a record while a finished result waits; the whole
// pipe holds only when the input register and the result register are full and unread
module windowed_event_rate_stats #(
    parameter int unsigned NUM_TYPES  = wers_pkg::DEF_NUM_TYPES,
    parameter int unsigned WINDOW_LEN = wers_pkg::DEF_WINDOW_LEN
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [wers_pkg::TIME_W-1:0]     i_record_time,
    input  logic [wers_pkg::CHAR_W-1:0]     i_type_char,
    input  logic [wers_pkg::CHAR_W-1:0]     i_status_char,
    input  logic [wers_pkg::RESP_W-1:0]     i_response_us,

    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_rate_valid,
    output logic [wers_pkg::TIME_W-1:0]     o_rate_time,
    output logic [wers_pkg::RATE_W-1:0]     o_rate_type0,
    output logic [wers_pkg::RATE_W-1:0]     o_rate_type1,
    output logic [wers_pkg::RATE_W-1:0]     o_rate_type2,
    output logic [wers_pkg::RATE_W-1:0]     o_rate_type3,
    output logic [wers_pkg::RATE_W-1:0]     o_rate_type4,
    output logic                            o_counted,
    output logic [wers_pkg::TOT_W-1:0]      o_type_total,
    output logic [wers_pkg::TOT_W-1:0]      o_type_rollbacks,
    output logic [wers_pkg::TOT_W-1:0]      o_error_total,
    output logic [wers_pkg::RSUM_W-1:0]     o_type_resp_sum,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wers_pkg::PADDR_W-1:0]    paddr,
    input  logic [wers_pkg::PDATA_W-1:0]    pwdata,
    output logic [wers_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    localparam int unsigned TY_W   = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int unsigned TOT_W  = wers_pkg::TOT_W;
    localparam int unsigned RSUM_W = wers_pkg::RSUM_W;
    localparam int unsigned RATE_W = wers_pkg::RATE_W;
    localparam int unsigned NF     = wers_pkg::RATE_FIELDS;

    // config registers
    logic r_skip_start;
    logic r_rate_en;
    logic cfg_wr;
    logic cfg_sel;

    // input register
    logic                          r_s1_vld;
    logic [wers_pkg::TIME_W-1:0]   r_s1_time;
    logic [wers_pkg::CHAR_W-1:0]   r_s1_type;
    logic [wers_pkg::CHAR_W-1:0]   r_s1_status;
    logic [wers_pkg::RESP_W-1:0]   r_s1_resp;

    // totals
    logic                          r_started;
    logic [TOT_W-1:0]              r_type_cnt [NUM_TYPES];
    logic [TOT_W-1:0]              r_rb_cnt   [NUM_TYPES];
    logic [RSUM_W-1:0]             r_rsum     [NUM_TYPES];
    logic [TOT_W-1:0]              r_err_cnt;

    // result register
    logic                          r_out_vld;
    logic                          r_out_rate_vld;
    logic [wers_pkg::TIME_W-1:0]   r_out_rate_time;
    logic [NF-1:0][RATE_W-1:0]     r_out_rate;
    logic                          r_out_counted;
    logic [TOT_W-1:0]              r_out_total;
    logic [TOT_W-1:0]              r_out_rb;
    logic [TOT_W-1:0]              r_out_err;
    logic [RSUM_W-1:0]             r_out_rsum;

    logic                                  s1_go;
    logic                                  nonzero;
    wers_pkg::t_type_hit                   th;
    logic                                  known;
    logic [TY_W-1:0]                       ty;
    logic                                  count_en;
    logic                                  is_rb;
    logic                                  is_err;
    wers_pkg::t_smp_req                    smp;
    wers_pkg::t_rate_hdr                   hdr;
    logic [NUM_TYPES-1:0][RATE_W-1:0]      win_sum;
    logic [NF-1:0][RATE_W-1:0]             rate_fld;
    logic [TOT_W-1:0]                      cnt_cur;
    logic [TOT_W-1:0]                      rb_cur;
    logic [RSUM_W-1:0]                     rsum_cur;
    logic [TOT_W-1:0]                      n_cnt;
    logic [TOT_W-1:0]                      n_rb;
    logic [TOT_W-1:0]                      n_err;
    logic [RSUM_W-1:0]                     n_rsum;
    logic [RSUM_W:0]                       rsum_add;

    // config port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = paddr[wers_pkg::PADDR_W-1];

    always_comb begin
        prdata = '0;
        unique case (cfg_sel)
            wers_pkg::REG_SKIP_START: prdata[0] = r_skip_start;
            wers_pkg::REG_RATE_EN:    prdata[0] = r_rate_en;
            default:                  prdata    = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_start <= 1'b0;
            r_rate_en    <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                wers_pkg::REG_SKIP_START: r_skip_start <= pwdata[0];
                wers_pkg::REG_RATE_EN:    r_rate_en    <= pwdata[0];
                default: ;
            endcase
        end
    end

    // pipeline control
    assign s1_go      = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_time   <= i_record_time;
            r_s1_type   <= i_type_char;
            r_s1_status <= i_status_char;
            r_s1_resp   <= i_response_us;
        end
    end

    // record decode
    assign nonzero = (r_s1_type != wers_pkg::CODE_NONE);
    assign th      = wers_pkg::find_type(r_s1_type, NUM_TYPES);
    assign known   = nonzero && th.hit;
    assign ty      = TY_W'(th.idx);

    assign smp.fire = s1_go && known && r_rate_en;
    assign smp.now  = r_s1_time;

    wers_window #(
        .NUM_TYPES  (NUM_TYPES),
        .WINDOW_LEN (WINDOW_LEN),
        .TY_W       (TY_W)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (smp),
        .i_ty       (ty),
        .o_hdr      (hdr),
        .o_rate_sum (win_sum)
    );

    for (genvar k = 0; k < NF; k++) begin : g_rate
        if (k < NUM_TYPES) begin : g_used
            assign rate_fld[k] = win_sum[k];
        end else begin : g_unused
            assign rate_fld[k] = '0;
        end
    end

    // totals, the start record itself is not counted
    assign count_en = known && r_started;
    assign is_rb    = (r_s1_status == wers_pkg::MARK_ROLLBACK);
    assign is_err   = (r_s1_status == wers_pkg::MARK_ERROR);

    assign cnt_cur  = r_type_cnt[ty];
    assign rb_cur   = r_rb_cnt[ty];
    assign rsum_cur = r_rsum[ty];
    assign rsum_add = {1'b0, rsum_cur} + (RSUM_W + 1)'(r_s1_resp);

    always_comb begin
        n_cnt  = cnt_cur;
        n_rb   = rb_cur;
        n_rsum = rsum_cur;
        n_err  = r_err_cnt;
        if (count_en) begin
            n_cnt  = (cnt_cur == wers_pkg::TOT_MAX) ? cnt_cur : cnt_cur + 1'b1;
            n_rsum = rsum_add[RSUM_W] ? wers_pkg::RSUM_MAX : rsum_add[RSUM_W-1:0];
            if (is_rb) begin
                n_rb = (rb_cur == wers_pkg::TOT_MAX) ? rb_cur : rb_cur + 1'b1;
            end else if (is_err) begin
                n_err = (r_err_cnt == wers_pkg::TOT_MAX) ? r_err_cnt : r_err_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_err_cnt <= '0;
            for (int t = 0; t < NUM_TYPES; t++) begin
                r_type_cnt[t] <= '0;
                r_rb_cnt[t]   <= '0;
                r_rsum[t]     <= '0;
            end
        end else if (s1_go && nonzero) begin
            if (!r_started) begin
                if (r_s1_type == wers_pkg::MARK_START || r_skip_start) begin
                    r_started <= 1'b1;
                end
            end else if (th.hit) begin
                r_type_cnt[ty] <= n_cnt;
                r_rb_cnt[ty]   <= n_rb;
                r_rsum[ty]     <= n_rsum;
                r_err_cnt      <= n_err;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_go) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_rate_vld  <= hdr.valid;
            r_out_rate_time <= hdr.valid ? hdr.closed_time : '0;
            r_out_rate      <= hdr.valid ? rate_fld : '0;
            r_out_counted   <= count_en;
            r_out_total     <= known ? n_cnt : '0;
            r_out_rb        <= known ? n_rb : '0;
            r_out_rsum      <= known ? n_rsum : '0;
            r_out_err       <= n_err;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_rate_valid     = r_out_rate_vld;
    assign o_rate_time      = r_out_rate_time;
    assign o_rate_type0     = r_out_rate[0];
    assign o_rate_type1     = r_out_rate[1];
    assign o_rate_type2     = r_out_rate[2];
    assign o_rate_type3     = r_out_rate[3];
    assign o_rate_type4     = r_out_rate[4];
    assign o_counted        = r_out_counted;
    assign o_type_total     = r_out_total;
    assign o_type_rollbacks = r_out_rb;
    assign o_error_total    = r_out_err;
    assign o_type_resp_sum  = r_out_rsum;

endmodule
